>>> rtl/rdc_pkg.sv
package rdc_pkg;

  localparam int unsigned VALUE_W    = 31;
  localparam int unsigned RADIX_W    = 5;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned MAX_DIGITS = 32;

  // Stack addressing: the depth counter must also hold MAX_DIGITS itself.
  localparam int unsigned ADDR_W  = $clog2(MAX_DIGITS);
  localparam int unsigned DEPTH_W = $clog2(MAX_DIGITS + 1);

  // Long division by the radix, a fixed number of quotient bits per cycle.
  localparam int unsigned REM_W          = DIGIT_W + 1;
  localparam int unsigned BITS_PER_CYCLE = 8;
  localparam int unsigned WORK_W         =
      ((VALUE_W + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE) * BITS_PER_CYCLE;
  localparam int unsigned DIV_CYCLES     = WORK_W / BITS_PER_CYCLE;
  localparam int unsigned CNT_W          = $clog2(DIV_CYCLES);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

  typedef struct packed {
    logic load;      // capture a new item and start dividing
    logic div_step;  // one step of the divider
    logic pop;       // read the top of the stack into the output register
    logic load_err;  // put the bad radix result into the output register
  } rdc_cmd_t;

  typedef struct packed {
    logic radix_bad;  // radix at the input lies outside the legal range
    logic last_step;  // this divider step finishes one digit
    logic quo_zero;   // quotient after this step is zero
    logic depth_one;  // exactly one digit left on the stack
    logic out_free;   // output register can take a new result this cycle
  } rdc_status_t;

endpackage

>>> rtl/rdc_if.sv
interface rdc_in_if;
  import rdc_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [RADIX_W-1:0] radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink (input valid, input value, input radix, output ready);
endinterface

interface rdc_out_if;
  import rdc_pkg::*;

  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit;
  logic               last_digit;
  logic               bad_radix;

  modport source (output valid, output digit, output last_digit, output bad_radix, input ready);
  modport sink (input valid, input digit, input last_digit, input bad_radix, output ready);
endinterface

>>> rtl/rdc_datapath.sv
module rdc_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [rdc_pkg::VALUE_W-1:0] value_i,
  input  logic [rdc_pkg::RADIX_W-1:0] radix_i,
  input  rdc_pkg::rdc_cmd_t           cmd_i,
  output rdc_pkg::rdc_status_t        status_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rdc_pkg::DIGIT_W-1:0] digit_o,
  output logic                        last_digit_o,
  output logic                        bad_radix_o
);
  import rdc_pkg::*;

  logic [RADIX_W-1:0] radix_q;
  logic [WORK_W-1:0]  work_q, work_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic [CNT_W-1:0]   cnt_q;
  logic [DEPTH_W-1:0] depth_q, depth_dec;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [DIGIT_W-1:0] stack_q [MAX_DIGITS];
  logic [DIGIT_W-1:0] digit_q;
  logic               last_q, bad_q, out_valid_q;
  logic               last_step, push, load_out;

  // Restoring division, MSB first. The remainder stays below the radix, so
  // after each shift it fits in REM_W bits.
  always_comb begin
    logic [WORK_W-1:0] w;
    logic [REM_W-1:0]  r;
    logic              ge;
    w  = work_q;
    r  = rem_q;
    ge = 1'b0;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      r  = {r[REM_W-2:0], w[WORK_W-1]};
      ge = (r >= REM_W'(radix_q));
      w  = {w[WORK_W-2:0], ge};
      if (ge) begin
        r = r - REM_W'(radix_q);
      end
    end
    work_d = w;
    rem_d  = r;
  end

  assign last_step = (cnt_q == CNT_W'(DIV_CYCLES - 1));
  assign push      = cmd_i.div_step && last_step && (depth_q < DEPTH_W'(MAX_DIGITS));
  assign depth_dec = depth_q - DEPTH_W'(1);
  assign wr_addr   = depth_q[ADDR_W-1:0];
  assign rd_addr   = depth_dec[ADDR_W-1:0];
  assign load_out  = cmd_i.pop || cmd_i.load_err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cnt_q   <= '0;
        depth_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (push) begin
          depth_q <= depth_q + DEPTH_W'(1);
        end
      end else if (cmd_i.pop) begin
        depth_q <= depth_dec;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      radix_q <= radix_i;
      work_q  <= WORK_W'(value_i);
      rem_q   <= '0;
    end else if (cmd_i.div_step) begin
      work_q <= work_d;
      rem_q  <= last_step ? '0 : rem_d;
    end
  end

  // Digit stack; the read data register doubles as the output register.
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_q[wr_addr] <= rem_d[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      digit_q <= stack_q[rd_addr];
      last_q  <= (depth_q == DEPTH_W'(1));
      bad_q   <= 1'b0;
    end else if (cmd_i.load_err) begin
      digit_q <= '0;
      last_q  <= 1'b1;
      bad_q   <= 1'b1;
    end
  end

  assign status_o.radix_bad = (radix_i < RADIX_MIN) || (radix_i > RADIX_MAX);
  assign status_o.last_step = last_step;
  assign status_o.quo_zero  = (work_d == '0);
  assign status_o.depth_one = (depth_q == DEPTH_W'(1));
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign digit_o      = digit_q;
  assign last_digit_o = last_q;
  assign bad_radix_o  = bad_q;

endmodule

>>> rtl/rdc_controller.sv
module rdc_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rdc_pkg::rdc_status_t status_i,
  output rdc_pkg::rdc_cmd_t    cmd_o
);
  import rdc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_POP  = 4'b0100,
    ST_ERR  = 4'b1000
  } rdc_state_e;

  rdc_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (status_i.radix_bad) begin
            state_d = ST_ERR;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.last_step && status_i.quo_zero) begin
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        if (status_i.out_free) begin
          cmd_o.pop = 1'b1;
          if (status_i.depth_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (status_i.out_free) begin
          cmd_o.load_err = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/radix_digit_converter.sv
// Integer radix converter. The input channel carries a 31-bit unsigned value
// and a radix; the output channel returns the digits of the value in that
// radix, most significant first, one digit per transfer, with last_digit set
// on the final one. A zero value gives the single digit 0. A radix outside
// 2..16 gives one result with bad_radix and last_digit set and digit 0.
// The value is divided by the radix in a shared long-division unit that
// resolves 8 quotient bits per cycle, and the remainder of each digit is
// pushed on a 32-entry digit stack. The stack is then popped through its
// single read port, one digit per cycle into the output register while that
// register is free. One item is worked on at a time; the next is accepted as
// soon as the last digit has left the stack, while that digit may still wait
// in the output register. When the receiver stalls, the pop sequence holds
// and the pending result stays stable on the output channel. Reset returns
// the controller to idle and empties the stack and the output register.
module radix_digit_converter (
  input  logic      clk_i,
  input  logic      rst_ni,
  rdc_in_if.sink    in_i,
  rdc_out_if.source out_o
);
  import rdc_pkg::*;

  rdc_cmd_t    cmd;
  rdc_status_t status;

  rdc_controller u_controller (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rdc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (in_i.value),
    .radix_i      (in_i.radix),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .digit_o      (out_o.digit),
    .last_digit_o (out_o.last_digit),
    .bad_radix_o  (out_o.bad_radix)
  );

endmodule

>>> verif/radix_digit_converter_tb.sv
module radix_digit_converter_tb;
  import rdc_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 236;
  localparam int unsigned CALM_ITEMS   = 40;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned PLAN_ROWS    = 24;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last_digit;
    logic               bad_radix;
  } digit_result_t;

  // A row either carries its single result typed in, or leaves it to the predictor.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
    logic               known;
    digit_result_t      result;
  } plan_row_t;

  localparam digit_result_t NO_RESULT  = '{4'h0, 1'b0, 1'b0};
  localparam digit_result_t BAD_RESULT = '{4'h0, 1'b1, 1'b1};

  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    '{31'd0,          5'd10, 1'b1, '{4'h0, 1'b1, 1'b0}},
    '{31'd0,          5'd2,  1'b1, '{4'h0, 1'b1, 1'b0}},
    '{31'd1,          5'd2,  1'b1, '{4'h1, 1'b1, 1'b0}},
    '{31'd15,         5'd16, 1'b1, '{4'hf, 1'b1, 1'b0}},
    '{31'd9,          5'd10, 1'b1, '{4'h9, 1'b1, 1'b0}},
    '{31'h7fffffff,   5'd2,  1'b0, NO_RESULT},
    '{31'h7fffffff,   5'd16, 1'b0, NO_RESULT},
    '{31'h7fffffff,   5'd3,  1'b0, NO_RESULT},
    '{31'h2aaaaaaa,   5'd4,  1'b0, NO_RESULT},
    '{31'h55555555,   5'd8,  1'b0, NO_RESULT},
    '{31'd16,         5'd16, 1'b0, NO_RESULT},
    '{31'd1000,       5'd5,  1'b0, NO_RESULT},
    '{31'd1000,       5'd6,  1'b0, NO_RESULT},
    '{31'd1000,       5'd7,  1'b0, NO_RESULT},
    '{31'd1000,       5'd9,  1'b0, NO_RESULT},
    '{31'd1000,       5'd11, 1'b0, NO_RESULT},
    '{31'd1000,       5'd12, 1'b0, NO_RESULT},
    '{31'd1000,       5'd13, 1'b0, NO_RESULT},
    '{31'd1000,       5'd14, 1'b0, NO_RESULT},
    '{31'd1000,       5'd15, 1'b0, NO_RESULT},
    '{31'd0,          5'd0,  1'b1, BAD_RESULT},
    '{31'd5,          5'd1,  1'b1, BAD_RESULT},
    '{31'h7fffffff,   5'd17, 1'b1, BAD_RESULT},
    '{31'd123,        5'd31, 1'b1, BAD_RESULT}
  };

  logic clk_i;
  logic rst_ni;

  rdc_in_if  conv_in ();
  rdc_out_if conv_out ();

  radix_digit_converter i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (conv_in),
    .out_o  (conv_out)
  );

  digit_result_t      digits_due [$];
  logic [DIGIT_W-1:0] shadow_stack [MAX_DIGITS];
  logic [DEPTH_W-1:0] shadow_depth;

  bit          calm;
  int unsigned errors;
  int unsigned conversions_sent;
  int unsigned bad_radix_sent;
  int unsigned digits_checked;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void push_shadow(input logic [DIGIT_W-1:0] digit);
    if (shadow_depth < DEPTH_W'(MAX_DIGITS)) begin
      shadow_stack[shadow_depth[ADDR_W-1:0]] = digit;
      shadow_depth++;
    end
  endfunction

  // Divides repeatedly, stacks the remainders, then unstacks them most significant
  // first into the queue of digits still to arrive; a bad radix gives BAD_RESULT.
  function automatic void convert_digits(input logic [VALUE_W-1:0] value,
                                         input logic [RADIX_W-1:0] radix);
    logic [VALUE_W-1:0] rest;
    logic [VALUE_W-1:0] divisor;
    digit_result_t      res;
    rest = value;
    divisor = VALUE_W'(radix);
    if (radix < RADIX_MIN || radix > RADIX_MAX) begin
      digits_due.push_back(BAD_RESULT);
      return;
    end
    shadow_depth = '0;
    while (rest >= divisor) begin
      push_shadow(DIGIT_W'(rest % divisor));
      rest = rest / divisor;
    end
    push_shadow(DIGIT_W'(rest));
    while (shadow_depth > 0) begin
      shadow_depth--;
      res.digit      = shadow_stack[shadow_depth[ADDR_W-1:0]];
      res.last_digit = (shadow_depth == 0);
      res.bad_radix  = 1'b0;
      digits_due.push_back(res);
    end
  endfunction

  // The optional gap comes before the item, so valid changes at most once per edge.
  task automatic send_conversion(input plan_row_t row);
    if (!calm && $urandom_range(0, 2) == 0) begin
      conv_in.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    conv_in.valid <= 1'b1;
    conv_in.value <= row.value;
    conv_in.radix <= row.radix;
    @(posedge clk_i);
    while (!conv_in.ready) @(posedge clk_i);
    if (row.known) begin
      digits_due.push_back(row.result);
    end else begin
      convert_digits(row.value, row.radix);
    end
    conversions_sent++;
    if (row.radix < RADIX_MIN || row.radix > RADIX_MAX) begin
      bad_radix_sent++;
    end
  endtask

  initial begin
    plan_row_t   row;
    int unsigned width;
    int unsigned pick;
    rst_ni        <= 1'b0;
    conv_in.valid <= 1'b0;
    conv_in.value <= '0;
    conv_in.radix <= '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      shadow_stack[i] = '0;
    end
    shadow_depth = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED_PLAN[i]) begin
      send_conversion(DIRECTED_PLAN[i]);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
      // Random bit lengths keep short values common next to full-width ones.
      width = $urandom_range(1, VALUE_W);
      row.value  = VALUE_W'($urandom) & VALUE_W'((64'd1 << width) - 1);
      row.known  = 1'b0;
      row.result = NO_RESULT;
      if ($urandom_range(0, 9) == 0) begin
        pick = $urandom_range(0, 16);
        row.radix = RADIX_W'(pick < 2 ? pick : pick + 15);
      end else begin
        row.radix = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
      end
      send_conversion(row);
    end
    conv_in.valid <= 1'b0;

    while (digits_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Converted %0d values, %0d of them with an illegal radix,", conversions_sent,
             bad_radix_sent);
    $display("and checked %0d digit transfers against the predicted digits.",
             digits_checked);
    if (errors == 0 && digits_due.size() == 0) begin
      $display("radix_digit_converter_tb: done, clean");
    end else begin
      $display("radix_digit_converter_tb: done, errors");
    end
    $finish;
  end

  // The receiver stalls in random bursts until the calm stretch at the end.
  initial begin
    conv_out.ready <= 1'b0;
    repeat (7) @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        conv_out.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      conv_out.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    digit_result_t got;
    digit_result_t want;
    if (rst_ni && conv_out.valid && conv_out.ready) begin
      got.digit      = conv_out.digit;
      got.last_digit = conv_out.last_digit;
      got.bad_radix  = conv_out.bad_radix;
      digits_checked++;
      if (digits_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("unexpected transfer: digit %h last_digit %b bad_radix %b",
                   got.digit, got.last_digit, got.bad_radix);
        end
      end else begin
        want = digits_due.pop_front();
        if (got.digit !== want.digit || got.last_digit !== want.last_digit ||
            got.bad_radix !== want.bad_radix) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("digit mismatch: expected digit %h last_digit %b bad_radix %b, got %h %b %b",
                     want.digit, want.last_digit, want.bad_radix,
                     got.digit, got.last_digit, got.bad_radix);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d digits outstanding", cycle_count,
               digits_due.size());
      $display("radix_digit_converter_tb: done, errors");
      $finish;
    end
  end

endmodule

>>> files.f
rtl/rdc_pkg.sv
rtl/rdc_if.sv
rtl/rdc_datapath.sv
rtl/rdc_controller.sv
rtl/radix_digit_converter.sv
verif/radix_digit_converter_tb.sv
